[hdl/cyl_pkg.sv]
// ----------------------------------------------------------------------------
// cyl_pkg
// Shared constants and the arctangent table for the cylinder geometry block.
// ----------------------------------------------------------------------------
package cyl_pkg;

    localparam int ANGLE_W = 17;
    localparam int THETA_W = 18;
    localparam int XY_W    = 34;
    localparam int OUT_W   = 16;

    localparam logic [THETA_W-1:0] OFFSET_Q16  = 18'd47940;
    localparam logic [THETA_W-1:0] HALF_PI_Q16 = 18'd102944;
    localparam logic [THETA_W-1:0] PI_Q16      = 18'd205887;

    localparam logic [30:0] SUMSQ_FIX = 31'd1143369295;
    localparam logic [29:0] TWOAB_FIX = 30'd703457264;
    localparam logic [23:0] ABDIV_Q16 = 24'd8179736;
    localparam logic [23:0] LMAX_Q16  = 24'd9355264;

    localparam logic [OUT_W-1:0] OUT_MAX = 16'hFFFF;

    // atan(2^-i) in Q30, rounded to nearest.
    function automatic logic [30:0] cyl_atan(input int unsigned i);
        logic [30:0] a;
        case (i)
            0:       a = 31'd843314857;
            1:       a = 31'd497837829;
            2:       a = 31'd263043837;
            3:       a = 31'd133525159;
            4:       a = 31'd67021687;
            5:       a = 31'd33543516;
            6:       a = 31'd16775851;
            7:       a = 31'd8388437;
            8:       a = 31'd4194283;
            9:       a = 31'd2097149;
            10:      a = 31'd1048576;
            11:      a = 31'd524288;
            12:      a = 31'd262144;
            13:      a = 31'd131072;
            14:      a = 31'd65536;
            15:      a = 31'd32768;
            16:      a = 31'd16384;
            17:      a = 31'd8192;
            18:      a = 31'd4096;
            19:      a = 31'd2048;
            20:      a = 31'd1024;
            21:      a = 31'd512;
            22:      a = 31'd256;
            23:      a = 31'd128;
            default: a = 31'd0;
        endcase
        return a;
    endfunction

endpackage

[hdl/cyl_cordic.sv]
// ----------------------------------------------------------------------------
// cyl_cordic
// Angle fold and pipelined rotation CORDIC, one stage per iteration.
// ----------------------------------------------------------------------------
module cyl_cordic
    import cyl_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [ANGLE_W-1:0]     angle,
    output logic                   out_valid,
    output logic signed [XY_W-1:0] x,
    output logic signed [XY_W-1:0] y,
    output logic                   neg
);

    logic signed [XY_W-1:0] x_reg [0:STAGES];
    logic signed [XY_W-1:0] y_reg [0:STAGES];
    logic signed [XY_W-1:0] z_reg [0:STAGES];
    logic                   neg_reg [0:STAGES];
    logic                   v_reg [0:STAGES];

    logic [THETA_W-1:0] theta;
    logic [THETA_W-1:0] theta_next;
    logic               neg_next;

    // Angles past a right angle are folded back; the cosine is negated later.
    always_comb
    begin
        theta = THETA_W'(angle) + OFFSET_Q16;
        if (theta > HALF_PI_Q16)
        begin
            theta_next = PI_Q16 - theta;
            neg_next   = 1'b1;
        end
        else
        begin
            theta_next = theta;
            neg_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= XY_W'(64'sd1073741824);
            y_reg[0]   <= '0;
            z_reg[0]   <= signed'(XY_W'({theta_next, 14'b0}));
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [XY_W-1:0] ATAN = signed'(XY_W'(cyl_atan(i)));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][XY_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign x         = x_reg[STAGES];
    assign y         = y_reg[STAGES];
    assign neg       = neg_reg[STAGES];

endmodule

[hdl/cyl_sqrt.sv]
// ----------------------------------------------------------------------------
// cyl_sqrt
// Pipelined integer square root, one result bit per stage, with remainder.
// ----------------------------------------------------------------------------
module cyl_sqrt
#(
    parameter int IN_W = 32,
    parameter int SB_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [SB_W-1:0]     sb_in,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [IN_W-1:0]     rem,
    output logic [SB_W-1:0]     sb_out
);

    localparam int RW = IN_W / 2;
    localparam int CW = IN_W + 2;

    logic [CW-1:0]   rem_reg  [0:RW];
    logic [RW-1:0]   root_reg [0:RW];
    logic [SB_W-1:0] sb_reg   [0:RW];
    logic            v_reg    [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= CW'(radicand);
            root_reg[0] <= '0;
            sb_reg[0]   <= sb_in;
        end
    end

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        localparam int B = RW - 1 - j;
        logic [CW-1:0] term;

        // Trial root r + 2^B squares to r^2 + r*2^(B+1) + 2^(2B).
        assign term = (CW'(root_reg[j]) << (B + 1)) + (CW'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (en)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[j] >= term)
                begin
                    rem_reg[j+1]  <= rem_reg[j] - term;
                    root_reg[j+1] <= root_reg[j] | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[j+1]  <= rem_reg[j];
                    root_reg[j+1] <= root_reg[j];
                end
                sb_reg[j+1] <= sb_reg[j];
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign root      = root_reg[RW];
    assign rem       = rem_reg[RW][IN_W-1:0];
    assign sb_out    = sb_reg[RW];

endmodule

[hdl/cyl_div.sv]
// ----------------------------------------------------------------------------
// cyl_div
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
// ----------------------------------------------------------------------------
module cyl_div
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16,
    parameter int QW    = 16,
    parameter int SB_W  = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_valid,
    output logic [QW-1:0]    quot,
    output logic             ovf,
    output logic [SB_W-1:0]  sb_out
);

    localparam int CW = NUM_W + DEN_W + QW;

    logic [CW-1:0]    rem_reg [0:QW];
    logic [DEN_W-1:0] den_reg [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];
    logic             ovf_reg [0:QW];
    logic [SB_W-1:0]  sb_reg  [0:QW];
    logic             v_reg   [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    // A quotient that does not fit in QW bits is flagged up front.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= CW'(num) >= (CW'(den) << QW);
            sb_reg[0]  <= sb_in;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int B = QW - 1 - j;
        logic [CW-1:0] dsh;

        assign dsh = CW'(den_reg[j]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j+1] <= 1'b0;
            else if (en)
                v_reg[j+1] <= v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[j] >= dsh)
                begin
                    rem_reg[j+1] <= rem_reg[j] - dsh;
                    q_reg[j+1]   <= q_reg[j] | (QW'(1) << B);
                end
                else
                begin
                    rem_reg[j+1] <= rem_reg[j];
                    q_reg[j+1]   <= q_reg[j];
                end
                den_reg[j+1] <= den_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                sb_reg[j+1]  <= sb_reg[j];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quot      = q_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign sb_out    = sb_reg[QW];

endmodule

[hdl/cylinder_stroke_and_arm.sv]
// ----------------------------------------------------------------------------
// cylinder_stroke_and_arm
// Rod length, lever arm and stroke gain of a hinged cylinder from boom angle.
//
// An item enters on the boom channel (boom_valid, boom_stall, boom_angle) and
// its result leaves on the result channel (result_valid, result_stall,
// rod_length, lever_arm, stroke_gain), one result for every item, in order.
// The datapath is a single pipeline: CORDIC, magnitude square root, two
// normalising dividers, cosine-law multiply, length square root, lever and
// gain dividers, and the gain square root. One item is taken every cycle
// while the pipeline is not frozen by result_stall.
// When result_stall holds a finished result, the whole pipeline freezes and
// boom_stall rises in the same cycle; nothing is lost or repeated, and the
// pipeline moves again at the first edge at which result_stall is low.
// Reset clears every valid bit; there is no state between items and no
// clearing pass.
// ----------------------------------------------------------------------------
module cylinder_stroke_and_arm
    import cyl_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               boom_valid,
    output logic               boom_stall,
    input  logic [ANGLE_W-1:0] boom_angle,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [OUT_W-1:0]   rod_length,
    output logic [OUT_W-1:0]   lever_arm,
    output logic [OUT_W-1:0]   stroke_gain
);

    logic en;

    // CORDIC
    logic                   cor_valid;
    logic signed [XY_W-1:0] cor_x;
    logic signed [XY_W-1:0] cor_y;
    logic                   cor_neg;

    // Squares
    logic [XY_W-1:0] x_abs;
    logic [XY_W-1:0] y_abs;
    logic            sq_v_reg;
    logic [61:0]     xx_reg;
    logic [61:0]     yy_reg;
    logic [30:0]     ax_reg;
    logic [30:0]     ay_reg;
    logic            xs_reg;
    logic            ys_reg;
    logic            sq_neg_reg;

    // Magnitude
    logic        mag_valid;
    logic [31:0] mag_root;
    logic [63:0] mag_rem;
    logic [64:0] mag_sb;
    logic [61:0] numx;
    logic [61:0] numy;
    logic        mag_zero;

    // Normalising dividers
    logic        dc_valid;
    logic [30:0] dc_q;
    logic        dc_ovf;
    logic [2:0]  dc_sb;
    logic        ds_valid;
    logic [30:0] ds_q;
    logic        ds_ovf;
    logic [1:0]  ds_sb;

    logic        cs_v_reg;
    logic [30:0] cm_reg;
    logic        csign_reg;
    logic [30:0] s_reg;

    logic        pr_v_reg;
    logic [60:0] prod_reg;
    logic        pr_sign_reg;
    logic [30:0] pr_s_reg;

    logic [61:0]        prod_rnd;
    logic signed [33:0] l2_full;
    logic               l2_v_reg;
    logic [30:0]        l2_reg;
    logic [30:0]        l2_s_reg;

    // Length
    logic        len_valid;
    logic [23:0] len_root;
    logic [47:0] len_rem;
    logic [30:0] len_sb;

    logic        lq_v_reg;
    logic [24:0] lq_reg;
    logic [30:0] lq_s_reg;

    logic        ln_v_reg;
    logic [54:0] lnum_reg;
    logic [24:0] ln_lq_reg;

    logic [55:0] lnum_rnd;
    logic [25:0] rod_rnd;
    logic        dv_v_reg;
    logic [41:0] n1_reg;
    logic [51:0] n2_reg;
    logic [24:0] dv_lq_reg;
    logic [15:0] rod_reg;
    logic        lqzero_reg;

    // Lever and gain dividers
    logic        dl_valid;
    logic [31:0] dl_q;
    logic        dl_ovf;
    logic [16:0] dl_sb;
    logic        dg_valid;
    logic [31:0] dg_q;
    logic        dg_ovf;
    logic        dg_sb;

    logic        lv_v_reg;
    logic [15:0] lv_reg;
    logic [15:0] lv_rod_reg;
    logic        gsat_reg;
    logic [31:0] gq_reg;

    // Gain square root
    logic        gs_valid;
    logic [15:0] gs_root;
    logic [31:0] gs_rem;
    logic [32:0] gs_sb;
    logic [16:0] gain_rnd;

    logic             out_v_reg;
    logic [OUT_W-1:0] rod_out_reg;
    logic [OUT_W-1:0] lever_out_reg;
    logic [OUT_W-1:0] gain_out_reg;

    assign en         = !(out_v_reg && result_stall);
    assign boom_stall = !en;

    cyl_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (boom_valid),
        .angle     (boom_angle),
        .out_valid (cor_valid),
        .x         (cor_x),
        .y         (cor_y),
        .neg       (cor_neg)
    );

    always_comb
    begin
        x_abs = cor_x[XY_W-1] ? XY_W'(-cor_x) : XY_W'(cor_x);
        y_abs = cor_y[XY_W-1] ? XY_W'(-cor_y) : XY_W'(cor_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg <= 1'b0;
        else if (en)
            sq_v_reg <= cor_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg     <= 62'(x_abs[30:0] * x_abs[30:0]);
            yy_reg     <= 62'(y_abs[30:0] * y_abs[30:0]);
            ax_reg     <= x_abs[30:0];
            ay_reg     <= y_abs[30:0];
            xs_reg     <= cor_x[XY_W-1];
            ys_reg     <= cor_y[XY_W-1];
            sq_neg_reg <= cor_neg;
        end
    end

    cyl_sqrt #(
        .IN_W (64),
        .SB_W (65)
    ) u_mag_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v_reg),
        .radicand  (64'(xx_reg) + 64'(yy_reg)),
        .sb_in     ({xs_reg, ys_reg, sq_neg_reg, ax_reg, ay_reg}),
        .out_valid (mag_valid),
        .root      (mag_root),
        .rem       (mag_rem),
        .sb_out    (mag_sb)
    );

    // Components over magnitude in Q30, rounded by adding half the divisor.
    always_comb
    begin
        numx     = {1'b0, mag_sb[61:31], 30'b0} + 62'(mag_root[31:1]);
        numy     = {1'b0, mag_sb[30:0], 30'b0} + 62'(mag_root[31:1]);
        mag_zero = (mag_root == '0);
    end

    cyl_div #(
        .NUM_W (62),
        .DEN_W (32),
        .QW    (31),
        .SB_W  (3)
    ) u_div_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mag_valid),
        .num       (numx),
        .den       (mag_root),
        .sb_in     ({mag_sb[64], mag_sb[62], mag_zero}),
        .out_valid (dc_valid),
        .quot      (dc_q),
        .ovf       (dc_ovf),
        .sb_out    (dc_sb)
    );

    cyl_div #(
        .NUM_W (62),
        .DEN_W (32),
        .QW    (31),
        .SB_W  (2)
    ) u_div_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mag_valid),
        .num       (numy),
        .den       (mag_root),
        .sb_in     ({mag_sb[63], mag_zero}),
        .out_valid (ds_valid),
        .quot      (ds_q),
        .ovf       (ds_ovf),
        .sb_out    (ds_sb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cs_v_reg <= 1'b0;
        else if (en)
            cs_v_reg <= dc_valid && ds_valid;
    end

    // A negative sine from rounding is taken as zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dc_sb[0])
                cm_reg <= '0;
            else if (dc_ovf)
                cm_reg <= '1;
            else
                cm_reg <= dc_q;
            csign_reg <= dc_sb[2] ^ dc_sb[1];
            if (ds_sb[1] || ds_sb[0])
                s_reg <= '0;
            else if (ds_ovf)
                s_reg <= '1;
            else
                s_reg <= ds_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_v_reg <= 1'b0;
        else if (en)
            pr_v_reg <= cs_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= 61'(TWOAB_FIX * cm_reg);
            pr_sign_reg <= csign_reg;
            pr_s_reg    <= s_reg;
        end
    end

    always_comb
    begin
        prod_rnd = 62'(prod_reg) + (62'(1) << 29);
        if (pr_sign_reg)
            l2_full = 34'(SUMSQ_FIX) + 34'(prod_rnd[61:30]);
        else
            l2_full = 34'(SUMSQ_FIX) - 34'(prod_rnd[61:30]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l2_v_reg <= 1'b0;
        else if (en)
            l2_v_reg <= pr_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2_reg   <= l2_full[33] ? '0 : l2_full[30:0];
            l2_s_reg <= pr_s_reg;
        end
    end

    cyl_sqrt #(
        .IN_W (48),
        .SB_W (31)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (l2_v_reg),
        .radicand  ({1'b0, l2_reg, 16'b0}),
        .sb_in     (l2_s_reg),
        .out_valid (len_valid),
        .root      (len_root),
        .rem       (len_rem),
        .sb_out    (len_sb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lq_v_reg <= 1'b0;
        else if (en)
            lq_v_reg <= len_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lq_reg   <= 25'(len_root) + 25'(len_rem > 48'(len_root));
            lq_s_reg <= len_sb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ln_v_reg <= 1'b0;
        else if (en)
            ln_v_reg <= lq_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lnum_reg  <= 55'(ABDIV_Q16 * lq_s_reg);
            ln_lq_reg <= lq_reg;
        end
    end

    // Lever divisor is Lq * 2^14; the low 14 bits fold into the numerator.
    always_comb
    begin
        lnum_rnd = 56'(lnum_reg) + 56'({ln_lq_reg, 13'b0});
        rod_rnd  = 26'(ln_lq_reg) + 26'd128;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg <= 1'b0;
        else if (en)
            dv_v_reg <= ln_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg     <= lnum_rnd[55:14];
            n2_reg     <= {LMAX_Q16, 28'b0} + 52'(ln_lq_reg[24:1]);
            dv_lq_reg  <= ln_lq_reg;
            rod_reg    <= (rod_rnd[25:24] != 2'b00) ? OUT_MAX : rod_rnd[23:8];
            lqzero_reg <= (ln_lq_reg == '0);
        end
    end

    cyl_div #(
        .NUM_W (42),
        .DEN_W (25),
        .QW    (32),
        .SB_W  (17)
    ) u_div_lever (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_v_reg),
        .num       (n1_reg),
        .den       (dv_lq_reg),
        .sb_in     ({rod_reg, lqzero_reg}),
        .out_valid (dl_valid),
        .quot      (dl_q),
        .ovf       (dl_ovf),
        .sb_out    (dl_sb)
    );

    cyl_div #(
        .NUM_W (52),
        .DEN_W (25),
        .QW    (32),
        .SB_W  (1)
    ) u_div_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_v_reg),
        .num       (n2_reg),
        .den       (dv_lq_reg),
        .sb_in     (lqzero_reg),
        .out_valid (dg_valid),
        .quot      (dg_q),
        .ovf       (dg_ovf),
        .sb_out    (dg_sb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lv_v_reg <= 1'b0;
        else if (en)
            lv_v_reg <= dl_valid && dg_valid;
    end

    // A gain quotient past 32 bits has a root past 16 bits, so it saturates.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dl_sb[0] || dl_ovf || (dl_q[31:16] != '0))
                lv_reg <= OUT_MAX;
            else
                lv_reg <= dl_q[15:0];
            lv_rod_reg <= dl_sb[16:1];
            gsat_reg   <= dg_sb || dg_ovf;
            gq_reg     <= dg_q;
        end
    end

    cyl_sqrt #(
        .IN_W (32),
        .SB_W (33)
    ) u_gain_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lv_v_reg),
        .radicand  (gq_reg),
        .sb_in     ({lv_rod_reg, lv_reg, gsat_reg}),
        .out_valid (gs_valid),
        .root      (gs_root),
        .rem       (gs_rem),
        .sb_out    (gs_sb)
    );

    assign gain_rnd = 17'(gs_root) + 17'(gs_rem > 32'(gs_root));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= gs_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rod_out_reg   <= gs_sb[32:17];
            lever_out_reg <= gs_sb[16:1];
            if (gs_sb[0] || gain_rnd[16])
                gain_out_reg <= OUT_MAX;
            else
                gain_out_reg <= gain_rnd[15:0];
        end
    end

    assign result_valid = out_v_reg;
    assign rod_length   = rod_out_reg;
    assign lever_arm    = lever_out_reg;
    assign stroke_gain  = gain_out_reg;

endmodule

[tb/tb_cylinder_stroke_and_arm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cylinder_stroke_and_arm
// Self-checking bench for the cylinder rod length, lever arm and stroke gain.
// Boom angles are driven from a queue, each accepted angle is turned into the
// expected result by a bit-exact fixed-point model, and every result that
// leaves the block is compared field by field in order. Both sides idle at
// random, the receiver holds off once for a long stretch, and the sender once
// waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module tb_cylinder_stroke_and_arm
    import cyl_pkg::*;
();

    localparam int STAGES      = 16;
    localparam int N_RANDOM    = 850;
    localparam int DRAIN_WAIT  = 220;
    localparam int HOLD_CYCLES = 500;
    localparam int WD_LIMIT    = 3000;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [OUT_W-1:0] rod;
        logic [OUT_W-1:0] arm;
        logic [OUT_W-1:0] gain;
    } geom_t;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        bit                 drain_first;
    } angle_item_t;

    logic               clk;
    logic               rst_n;
    logic               boom_valid;
    logic               boom_stall;
    logic [ANGLE_W-1:0] boom_angle;
    logic               result_valid;
    logic               result_stall;
    logic [OUT_W-1:0]   rod_length;
    logic [OUT_W-1:0]   lever_arm;
    logic [OUT_W-1:0]   stroke_gain;

    angle_item_t pending_angles[$];
    geom_t       expected_geom[$];
    int          n_errors   = 0;
    int          n_sent     = 0;
    int          n_results  = 0;
    int          send_gap   = 0;
    int          recv_gap   = 0;
    int          hold_left  = 0;
    bit          hold_done  = 0;
    bit          drain_done = 0;
    int          idle_count = 0;

    cylinder_stroke_and_arm #(.CORDIC_STAGES(STAGES)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .boom_valid   (boom_valid),
        .boom_stall   (boom_stall),
        .boom_angle   (boom_angle),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .rod_length   (rod_length),
        .lever_arm    (lever_arm),
        .stroke_gain  (stroke_gain)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Arctangent of 2^-i in Q30, rounded; from its power series past i = 3.
    function automatic longint arctan_q30(input int i);
        longint unsigned pos;
        longint unsigned neg;
        int              k;
        int              e;
        bit              add;
        pos = 0;
        neg = 0;
        add = 1;
        case (i)
            0: return 843314857;
            1: return 497837829;
            2: return 263043837;
            3: return 133525159;
            default: ;
        endcase
        if (i >= 60)
            return 0;
        k = 1;
        e = 60 - i;
        while (e >= 0)
        begin
            if (add)
                pos += (64'd1 << e) / k;
            else
                neg += (64'd1 << e) / k;
            add = !add;
            k += 2;
            e = 60 - k * i;
        end
        return longint'(((pos - neg) + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned root_round(input longint unsigned v);
        longint unsigned s;
        s = root_floor(v);
        if (v - s * s > s)
            s++;
        return s;
    endfunction

    function automatic logic [OUT_W-1:0] clip16(input longint unsigned v);
        return (v > 65535) ? OUT_MAX : v[OUT_W-1:0];
    endfunction

    function automatic longint unit_ratio(input longint num, input longint unsigned mag);
        longint unsigned m;
        longint unsigned q;
        m = (num < 0) ? longint'(-num) : num;
        q = ((m << 30) + mag / 2) / mag;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic geom_t cylinder_geometry(input logic [ANGLE_W-1:0] angle);
        longint          theta;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          c;
        longint          s;
        longint          t;
        longint          l2;
        longint unsigned mag;
        longint unsigned lq;
        longint unsigned num;
        longint unsigned den;
        bit              flip_cos;
        geom_t           g;
        theta = longint'(angle) + longint'(OFFSET_Q16);
        flip_cos = 0;
        if (theta > longint'(HALF_PI_Q16))
        begin
            // Past a right angle the rotation works on the supplement.
            theta = longint'(PI_Q16) - theta;
            flip_cos = 1;
        end
        x = 64'sd1 << 30;
        y = 0;
        z = theta * 16384;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_q30(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_q30(i);
            end
        end
        mag = root_floor(longint'(x * x) + longint'(y * y));
        if (mag == 0)
        begin
            c = 0;
            s = 0;
        end
        else
        begin
            c = unit_ratio(x, mag);
            s = unit_ratio(y, mag);
        end
        if (flip_cos)
            c = -c;
        if (s < 0)
            s = 0;
        t = longint'(TWOAB_FIX) * c;
        if (t >= 0)
            t = longint'((u64_t'(t) + (64'd1 << 29)) >> 30);
        else
            t = -longint'((u64_t'(-t) + (64'd1 << 29)) >> 30);
        l2 = longint'(SUMSQ_FIX) - t;
        if (l2 < 0)
            l2 = 0;
        lq = root_round(u64_t'(l2) << 16);
        g.rod = clip16((lq + 128) >> 8);
        if (lq == 0)
        begin
            g.arm  = OUT_MAX;
            g.gain = OUT_MAX;
        end
        else
        begin
            num = u64_t'(ABDIV_Q16) * u64_t'(s);
            den = lq << 14;
            g.arm = clip16((num + den / 2) / den);
            num = ((u64_t'(LMAX_Q16) << 28) + lq / 2) / lq;
            g.gain = clip16(root_round(num));
        end
        return g;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic queue_angle(input logic [ANGLE_W-1:0] a, input bit drain);
        angle_item_t it;
        it.angle = a;
        it.drain_first = drain;
        pending_angles.push_back(it);
    endtask

    // Sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boom_valid <= 1'b0;
            boom_angle <= '0;
        end
        else
        begin
            if (boom_valid && !boom_stall)
            begin
                expected_geom.push_back(cylinder_geometry(boom_angle));
                n_sent++;
            end
            if (!boom_valid || !boom_stall)
            begin
                if (pending_angles.size() == 0)
                    boom_valid <= 1'b0;
                else if (pending_angles[0].drain_first
                         && (expected_geom.size() != 0 || boom_valid))
                    boom_valid <= 1'b0;
                else if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    boom_valid <= 1'b0;
                end
                else
                begin
                    if (pending_angles[0].drain_first)
                        drain_done <= 1;
                    boom_angle <= pending_angles[0].angle;
                    boom_valid <= 1'b1;
                    void'(pending_angles.pop_front());
                    // Bursts with no idling between stretches of random gaps.
                    send_gap <= ((n_sent / 100) % 3 == 1) ? 0 : pick_gap();
                end
            end
        end
    end

    // Receiver stall, including one long hold-off once results are flowing.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= (hold_left != 1);
        end
        else if (!hold_done && n_results >= 300)
        begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (result_valid && ((n_results / 120) % 3 != 2))
                recv_gap <= pick_gap();
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        geom_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_geom.size() == 0)
            begin
                $display("MISMATCH unexpected result %0d", n_results);
                n_errors++;
            end
            else
            begin
                want = expected_geom.pop_front();
                if (rod_length !== want.rod)
                    report_mismatch("rod_length", rod_length, want.rod);
                if (lever_arm !== want.arm)
                    report_mismatch("lever_arm", lever_arm, want.arm);
                if (stroke_gain !== want.gain)
                    report_mismatch("stroke_gain", stroke_gain, want.gain);
            end
            n_results++;
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((boom_valid && !boom_stall) || (result_valid && !result_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WD_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", WD_LIMIT);
            $display("cylinder_stroke_and_arm test failed");
            $finish;
        end
    end

    initial
    begin
        logic [ANGLE_W-1:0] a;
        rst_n = 1'b0;
        // Directed: range ends, the right-angle fold point, out-of-range input.
        queue_angle(17'd0, 0);
        queue_angle(17'd1, 0);
        queue_angle(17'd102944, 0);
        queue_angle(17'd102943, 0);
        queue_angle(17'd102945, 0);
        queue_angle(17'd55004, 0);
        queue_angle(17'd55003, 0);
        queue_angle(17'd55005, 0);
        queue_angle(17'h1FFFF, 0);
        queue_angle(17'h10000, 0);
        queue_angle(17'h0FFFF, 0);
        queue_angle(17'h15555, 0);
        queue_angle(17'h0AAAA, 0);
        queue_angle(17'd25736, 0);
        queue_angle(17'd51472, 0);
        queue_angle(17'd77208, 0);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if ($urandom_range(9) == 0)
                a = ANGLE_W'($urandom_range(17'h1FFFF));
            else
                a = ANGLE_W'($urandom_range(102944));
            queue_angle(a, n == 500);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_angles.size() == 0 && !boom_valid && drain_done);
        wait (expected_geom.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d boom angles across the full 17-bit range with random gaps,",
                 n_sent);
        $display("one long receiver hold-off and one full drain; %0d results checked.",
                 n_results);
        if (n_errors == 0 && expected_geom.size() == 0)
            $display("cylinder_stroke_and_arm test passed");
        else
            $display("cylinder_stroke_and_arm test failed");
        $finish;
    end

endmodule
